### sv/llpq_pkg.sv
// ----------------------------------------------------------------------------
// llpq_pkg
// Shared widths, operation codes and interface types of the linked-list
// packet queue unit.
// ----------------------------------------------------------------------------
package llpq_pkg;

  localparam int BUF_W   = 6;   // buffer number field
  localparam int QUEUE_W = 3;   // queue index field
  localparam int KIND_W  = 1;   // operation field
  localparam int EVT_W   = 8;   // notify event code
  localparam int CFG_W   = 64;  // packed event code register

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int NUM_BUFFERS_DEF = 64;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

  // One entry of the shared next-link store
  typedef struct packed {
    logic             vld;
    logic [BUF_W-1:0] nxt;
  } link_t;

  // Update request towards the queue table
  typedef struct packed {
    logic               enq;    // append ptr to the queue
    logic               deq;    // move head to ptr
    logic               more;   // on dequeue: a next buffer exists
    logic [QUEUE_W-1:0] queue;
    logic [BUF_W-1:0]   ptr;
  } qt_upd_t;

  // Head and tail state of one queue
  typedef struct packed {
    logic             head_valid;
    logic [BUF_W-1:0] head;
    logic [BUF_W-1:0] tail;
  } qt_stat_t;

endpackage

### sv/linked_list_packet_queues_unit.sv
// ----------------------------------------------------------------------------
// linked_list_packet_queues_unit
// FIFO queues of buffer numbers kept as singly linked lists in one shared
// next-link store, with a head and tail per queue.
// ----------------------------------------------------------------------------
// Start is taken while busy is low, busy is then high for one cycle, and
// out_strobe marks the result in the cycle after that, in which the next
// item may already be started. The busy state is set by the next-link store:
// a dequeue reads the head's link and only gets it back in the next cycle,
// and an enqueue writes two links (clear the new buffer's link, then point
// the old tail at it) through the single write port. The result cannot be
// held off by the receiver; it is shown for one
// cycle only. An enqueue reports the queue's event code from cfg_data byte
// <queue>; a dequeue of an empty queue reports buffer_valid low. An item on
// a queue index at or above NUM_QUEUES changes nothing and reports all zero.
// Write the event code register only while the unit is idle.
// ----------------------------------------------------------------------------
module linked_list_packet_queues_unit #(
  parameter int NUM_QUEUES  = llpq_pkg::NUM_QUEUES_DEF,
  parameter int NUM_BUFFERS = llpq_pkg::NUM_BUFFERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [llpq_pkg::KIND_W-1:0]   in_kind,
  input  logic [llpq_pkg::QUEUE_W-1:0]  in_queue,
  input  logic [llpq_pkg::BUF_W-1:0]    in_buffer_in,
  // result channel
  output logic                          out_strobe,
  output logic [llpq_pkg::BUF_W-1:0]    out_buffer_out,
  output logic                          out_buffer_valid,
  output logic [llpq_pkg::EVT_W-1:0]    out_event_code,
  output logic                          out_event_valid,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [llpq_pkg::CFG_W-1:0]    cfg_data
);
  import llpq_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BUFFERS);
  localparam int QCMP_W = QUEUE_W + 1;
  localparam int BCMP_W = BUF_W + 2;
  localparam logic [QCMP_W-1:0] NQ_L = QCMP_W'(NUM_QUEUES);
  localparam logic [BCMP_W-1:0] NB_L = BCMP_W'(NUM_BUFFERS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] evt_codes_r;

  // item held for the FIN state
  logic               enq_ok_r;     // enqueue on a valid queue
  logic               tail_lnk_r;   // old tail gets linked in FIN
  logic               deq_hit_r;    // dequeue found a head
  logic               head_ok_r;    // head indexes the link store
  logic [QUEUE_W-1:0] queue_r;
  logic [BUF_W-1:0]   buf_r;
  logic [BUF_W-1:0]   tail_r;
  logic [BUF_W-1:0]   head_r;
  logic [EVT_W-1:0]   evt_r;

  // result registers
  logic               strobe_r;
  logic [BUF_W-1:0]   res_buf_r;
  logic               res_bvld_r;
  logic [EVT_W-1:0]   res_evt_r;
  logic               res_evld_r;

  logic     accept;
  logic     in_fin;
  logic     q_ok;
  logic     b_ok;
  logic     t_ok;
  logic     h_ok;
  logic     is_enq;
  logic     is_deq;
  logic     enq_now;
  qt_stat_t qstat;
  qt_upd_t  qupd;
  link_t    lnk_rd;
  link_t    lnk_wdata;
  link_t    deq_lnk;
  logic     lnk_we;
  logic [ADDR_W-1:0] lnk_waddr;
  logic [ADDR_W-1:0] lnk_raddr;
  logic [BUF_W:0]    in_buf_ext;
  logic [BUF_W:0]    tail_ext;
  logic [BUF_W:0]    head_ext;
  logic [QUEUE_W+2:0] evt_sel;

  assign accept = start && !busy;
  assign in_fin = (state_r == ST_FIN);
  assign busy   = in_fin;

  // range checks
  assign q_ok = {1'b0, in_queue} < NQ_L;
  assign b_ok = {2'b00, in_buffer_in} < NB_L;
  assign t_ok = {2'b00, qstat.tail} < NB_L;
  assign h_ok = {2'b00, qstat.head} < NB_L;

  assign is_enq  = (in_kind == KIND_ENQ);
  assign is_deq  = (in_kind == KIND_DEQ);
  assign enq_now = accept && is_enq && q_ok && b_ok;

  assign in_buf_ext = {1'b0, in_buffer_in};
  assign tail_ext   = {1'b0, tail_r};
  assign head_ext   = {1'b0, qstat.head};
  assign evt_sel    = {in_queue, 3'b000};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Event code register: always ready
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_codes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      evt_codes_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Capture the item and the queue state seen at the accept edge
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enq_ok_r   <= 1'b0;
      tail_lnk_r <= 1'b0;
      deq_hit_r  <= 1'b0;
    end else if (accept) begin
      enq_ok_r   <= is_enq && q_ok;
      tail_lnk_r <= is_enq && q_ok && b_ok && qstat.head_valid && t_ok;
      deq_hit_r  <= is_deq && q_ok && qstat.head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue_r   <= in_queue;
      buf_r     <= in_buffer_in;
      tail_r    <= qstat.tail;
      head_r    <= qstat.head;
      head_ok_r <= h_ok;
      evt_r     <= evt_codes_r[evt_sel +: EVT_W];
    end
  end

  // --------------------------------------------------------------------------
  // Queue table: enqueue updates at accept, dequeue once the link is back
  // --------------------------------------------------------------------------
  assign deq_lnk = head_ok_r ? lnk_rd : '0;

  always_comb begin
    qupd = '0;
    if (enq_now) begin
      qupd.enq   = 1'b1;
      qupd.queue = in_queue;
      qupd.ptr   = in_buffer_in;
    end else if (in_fin && deq_hit_r) begin
      qupd.deq   = 1'b1;
      qupd.more  = deq_lnk.vld;
      qupd.queue = queue_r;
      qupd.ptr   = deq_lnk.nxt;
    end
  end

  llpq_queue_table #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_qtab (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_queue (in_queue),
    .stat     (qstat),
    .upd      (qupd)
  );

  // --------------------------------------------------------------------------
  // Link store: clear the new buffer's link at accept, then link the old
  // tail to it in FIN (a re-enqueued tail thus ends up linking to itself).
  // Busy keeps the next item off until both writes are done, so a read
  // never meets a pending write to the same entry.
  // --------------------------------------------------------------------------
  always_comb begin
    lnk_we    = 1'b0;
    lnk_waddr = in_buf_ext[ADDR_W-1:0];
    lnk_wdata = '0;
    if (enq_now) begin
      lnk_we = 1'b1;
    end else if (in_fin && tail_lnk_r) begin
      lnk_we        = 1'b1;
      lnk_waddr     = tail_ext[ADDR_W-1:0];
      lnk_wdata.vld = 1'b1;
      lnk_wdata.nxt = buf_r;
    end
  end

  assign lnk_raddr = head_ext[ADDR_W-1:0];

  llpq_link_mem #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_links (
    .clk     (clk),
    .wr_en   (lnk_we),
    .wr_addr (lnk_waddr),
    .wr_data (lnk_wdata),
    .rd_en   (accept && is_deq),
    .rd_addr (lnk_raddr),
    .rd_data (lnk_rd)
  );

  // --------------------------------------------------------------------------
  // Result: registered at the end of FIN, shown for one cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fin) begin
      res_buf_r  <= deq_hit_r ? head_r : '0;
      res_bvld_r <= deq_hit_r;
      res_evt_r  <= enq_ok_r ? evt_r : '0;
      res_evld_r <= enq_ok_r;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_buffer_out   = res_buf_r;
  assign out_buffer_valid = res_bvld_r;
  assign out_event_code   = res_evt_r;
  assign out_event_valid  = res_evld_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("item accepted without a result two cycles later");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while an item is still at work");

  a_one_kind_of_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_buffer_valid && out_event_valid))
    else $error("result reports both a buffer and an event");

  a_buffer_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_buffer_valid) |-> (out_buffer_out == '0))
    else $error("buffer number not zero on a result without a buffer");

  a_single_queue_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(qupd.enq && qupd.deq))
    else $error("queue table asked to enqueue and dequeue at once");

endmodule

### sv/llpq_link_mem.sv
// ----------------------------------------------------------------------------
// llpq_link_mem
// Next-link store shared by all queues: one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module llpq_link_mem #(
  parameter int NUM_BUFFERS = llpq_pkg::NUM_BUFFERS_DEF,
  parameter int ADDR_W      = $clog2(NUM_BUFFERS)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  llpq_pkg::link_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output llpq_pkg::link_t     rd_data
);
  import llpq_pkg::*;

  link_t mem [NUM_BUFFERS];
  link_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/llpq_queue_table.sv
// ----------------------------------------------------------------------------
// llpq_queue_table
// Head pointer, head valid bit and tail pointer of every queue, with one
// status read and one update per cycle.
// ----------------------------------------------------------------------------
module llpq_queue_table #(
  parameter int NUM_QUEUES = llpq_pkg::NUM_QUEUES_DEF,
  parameter int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [llpq_pkg::QUEUE_W-1:0]     rd_queue,
  output llpq_pkg::qt_stat_t               stat,
  input  llpq_pkg::qt_upd_t                upd
);
  import llpq_pkg::*;

  logic [BUF_W-1:0]      head_r [NUM_QUEUES];
  logic [BUF_W-1:0]      tail_r [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] hvld_r;

  logic [QIDX_W-1:0] rd_idx;
  logic [QIDX_W-1:0] up_idx;

  assign rd_idx = rd_queue[QIDX_W-1:0];
  assign up_idx = upd.queue[QIDX_W-1:0];

  assign stat.head_valid = hvld_r[rd_idx];
  assign stat.head       = head_r[rd_idx];
  assign stat.tail       = tail_r[rd_idx];

  // Valid bits: an empty queue starts its list on enqueue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r <= '0;
    end else if (upd.enq) begin
      hvld_r[up_idx] <= 1'b1;
    end else if (upd.deq) begin
      hvld_r[up_idx] <= upd.more;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (upd.enq) begin
      tail_r[up_idx] <= upd.ptr;
      if (!hvld_r[up_idx]) begin
        head_r[up_idx] <= upd.ptr;
      end
    end else if (upd.deq) begin
      head_r[up_idx] <= upd.ptr;
    end
  end

endmodule

### sim/tb_linked_list_packet_queues_unit.sv
// ----------------------------------------------------------------------------
// tb_linked_list_packet_queues_unit
// Self-checking bench for the linked-list packet queue unit. A short table of
// directed items (empty queues, extreme queue and buffer numbers, a tail
// buffer queued twice, one buffer in two queues) is followed by random
// phases under several event code settings. A shadow of the queue tables
// predicts each result; results are checked in order as they are strobed.
// ----------------------------------------------------------------------------
module tb_linked_list_packet_queues_unit;
  import llpq_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int NUM_Q          = NUM_QUEUES_DEF;
  localparam int NUM_B          = NUM_BUFFERS_DEF;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 4;    // a little over the time an item takes
  localparam int MAX_REPORTS    = 10;

  // One result item as the unit presents it
  typedef struct packed {
    logic [BUF_W-1:0] buffer_out;
    logic             buffer_valid;
    logic [EVT_W-1:0] event_code;
    logic             event_valid;
  } op_result_t;

  // One row of the directed table
  typedef struct packed {
    logic               set_codes;  // drain and write codes before the item
    logic [CFG_W-1:0]   codes;
    logic [KIND_W-1:0]  kind;
    logic [QUEUE_W-1:0] queue;
    logic [BUF_W-1:0]   buffer;
    logic               typed;      // expected result given in the row
    op_result_t         result;
  } stim_row_t;

  localparam op_result_t RES_NONE = '0;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  logic [KIND_W-1:0]  in_kind    = '0;
  logic [QUEUE_W-1:0] in_queue   = '0;
  logic [BUF_W-1:0]   in_buffer_in = '0;
  logic               out_strobe;
  logic [BUF_W-1:0]   out_buffer_out;
  logic               out_buffer_valid;
  logic [EVT_W-1:0]   out_event_code;
  logic               out_event_valid;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data   = '0;

  // Typed expectation travelling with the item being offered
  logic               row_typed  = 1'b0;
  op_result_t         row_result = '0;

  // Shadow of the unit's queue tables and event code register
  logic [CFG_W-1:0]   shadow_codes;
  logic [BUF_W-1:0]   shadow_head [NUM_Q];
  logic               shadow_head_vld [NUM_Q];
  logic [BUF_W-1:0]   shadow_tail [NUM_Q];
  link_t              shadow_link [NUM_B];

  op_result_t         awaited_results [$];
  stim_row_t          stim_table [$];
  logic               buf_in_use [NUM_B];  // steers enqueues towards free buffers

  int err_cnt      = 0;
  int item_cnt     = 0;
  int enq_cnt      = 0;
  int returned_cnt = 0;
  int empty_cnt    = 0;
  int codes_cnt    = 0;

  linked_list_packet_queues_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_queue         (in_queue),
    .in_buffer_in     (in_buffer_in),
    .out_strobe       (out_strobe),
    .out_buffer_out   (out_buffer_out),
    .out_buffer_valid (out_buffer_valid),
    .out_event_code   (out_event_code),
    .out_event_valid  (out_event_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the unit hangs
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("FAIL");
    $finish;
  end

  // Apply one item to the shadow tables and return the result it causes.
  function automatic op_result_t predict_queue_op(logic [KIND_W-1:0] kind,
                                                  logic [QUEUE_W-1:0] q,
                                                  logic [BUF_W-1:0] b);
    op_result_t       r;
    logic [BUF_W-1:0] old_tail;
    logic [BUF_W-1:0] h;
    link_t            lk;
    r = RES_NONE;
    // queue indexes beyond the table change nothing
    if (int'(q) >= NUM_Q) return r;
    if (kind == KIND_ENQ) begin
      if (int'(b) < NUM_B) begin
        // clear the new buffer's link first, then hang it off the old tail
        shadow_link[b] = '0;
        if (!shadow_head_vld[q]) begin
          shadow_head[q]     = b;
          shadow_tail[q]     = b;
          shadow_head_vld[q] = 1'b1;
        end else begin
          old_tail       = shadow_tail[q];
          shadow_tail[q] = b;
          if (int'(old_tail) < NUM_B) begin
            shadow_link[old_tail].vld = 1'b1;
            shadow_link[old_tail].nxt = b;
          end
        end
      end
      // the event is reported even when the buffer is out of range
      r.event_code  = shadow_codes[int'(q) * EVT_W +: EVT_W];
      r.event_valid = 1'b1;
    end else if (shadow_head_vld[q]) begin
      h  = shadow_head[q];
      lk = (int'(h) < NUM_B) ? shadow_link[h] : '0;
      r.buffer_out       = h;
      r.buffer_valid     = 1'b1;
      shadow_head[q]     = lk.nxt;
      shadow_head_vld[q] = lk.vld;
    end
    return r;
  endfunction

  function automatic void report_mismatch(string what, op_result_t want, op_result_t got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%s: want buf %0d/%0b evt %0h/%0b, got buf %0d/%0b evt %0h/%0b", what,
               want.buffer_out, want.buffer_valid, want.event_code, want.event_valid,
               got.buffer_out, got.buffer_valid, got.event_code, got.event_valid);
  endfunction

  // Scoreboard: check strobed results first, then log a newly taken item.
  // Everything is sampled at the rising edge; inputs only move at the
  // falling edge, so nothing here depends on event order.
  always @(posedge clk) begin : scoreboard
    op_result_t got;
    op_result_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        got.buffer_out   = out_buffer_out;
        got.buffer_valid = out_buffer_valid;
        got.event_code   = out_event_code;
        got.event_valid  = out_event_valid;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item outstanding", RES_NONE, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.buffer_out !== want.buffer_out || got.buffer_valid !== want.buffer_valid ||
              got.event_code !== want.event_code || got.event_valid !== want.event_valid)
            report_mismatch("result mismatch", want, got);
        end
        if (out_buffer_valid === 1'b1) buf_in_use[out_buffer_out] = 1'b0;
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        shadow_codes = cfg_data;
        codes_cnt++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = predict_queue_op(in_kind, in_queue, in_buffer_in);
        // a typed row overrides the prediction, the shadow still advances
        awaited_results.push_back(row_typed ? row_result : want);
        item_cnt++;
        if (in_kind == KIND_ENQ) begin
          enq_cnt++;
          buf_in_use[in_buffer_in] = 1'b1;
        end else if (want.buffer_valid) begin
          returned_cnt++;
        end else begin
          empty_cnt++;
        end
      end
    end
  end

  // Offer one item at the falling edge and hold it until it is taken.
  // Start stays high on return, so a following item goes straight on.
  task automatic issue_item(logic [KIND_W-1:0] kind, logic [QUEUE_W-1:0] q,
                            logic [BUF_W-1:0] b, logic typed, op_result_t res);
    start        <= 1'b1;
    in_kind      <= kind;
    in_queue     <= q;
    in_buffer_in <= b;
    row_typed    <= typed;
    row_result   <= res;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drop start and wait for every outstanding result, then let the unit settle
  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the packed event codes; only ever called with the unit idle
  task automatic write_event_codes(logic [CFG_W-1:0] codes);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= codes;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  function automatic int buffers_held();
    int n;
    n = 0;
    for (int i = 0; i < NUM_B; i++) if (buf_in_use[i]) n++;
    return n;
  endfunction

  function automatic void add_row(logic set_codes, logic [CFG_W-1:0] codes,
                                  logic [KIND_W-1:0] kind, int q, int b,
                                  logic typed, op_result_t res);
    stim_row_t row;
    row.set_codes = set_codes;
    row.codes     = codes;
    row.kind      = kind;
    row.queue     = q[QUEUE_W-1:0];
    row.buffer    = b[BUF_W-1:0];
    row.typed     = typed;
    row.result    = res;
    stim_table.push_back(row);
  endfunction

  // Random items: mostly enqueues of free buffers and dequeues on a few busy
  // queues, so lists grow deep; the rest re-queue buffers already in use.
  task automatic run_random_phase(int n_items, logic no_idle);
    logic [KIND_W-1:0]  kind;
    logic [QUEUE_W-1:0] q;
    logic [QUEUE_W-1:0] focus;
    logic [BUF_W-1:0]   b;
    int                 held;
    int                 enq_pct;
    focus = QUEUE_W'($urandom_range(0, NUM_Q - 1));
    for (int i = 0; i < n_items; i++) begin
      held    = buffers_held();
      enq_pct = (held < 8) ? 70 : (held > 48) ? 30 : 52;
      kind    = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
      q       = ($urandom_range(0, 99) < 60) ? focus : QUEUE_W'($urandom_range(0, NUM_Q - 1));
      b       = BUF_W'($urandom_range(0, NUM_B - 1));
      if (kind == KIND_ENQ && $urandom_range(0, 99) < 90) begin
        // hunt for a free buffer for a well-formed enqueue
        for (int t = 0; t < 16 && buf_in_use[b]; t++) b = BUF_W'($urandom_range(0, NUM_B - 1));
      end
      issue_item(kind, q, b, 1'b0, RES_NONE);
      if ($urandom_range(0, 99) < 2) begin
        drain_results();
      end else if (!no_idle) begin
        idle_for(pick_gap());
      end
      if ($urandom_range(0, 99) < 3) focus = QUEUE_W'($urandom_range(0, NUM_Q - 1));
    end
  endtask

  initial begin : stimulus
    stim_row_t row;
    shadow_codes = '0;
    for (int i = 0; i < NUM_Q; i++) begin
      shadow_head[i]     = '0;
      shadow_head_vld[i] = 1'b0;
      shadow_tail[i]     = '0;
    end
    for (int i = 0; i < NUM_B; i++) begin
      shadow_link[i] = '0;
      buf_in_use[i]  = 1'b0;
    end

    // Reset codes are all zero: empty queues, extreme queues and buffers
    add_row(0, '0, KIND_DEQ, 0, 0, 1, RES_NONE);
    add_row(0, '0, KIND_DEQ, 7, 63, 1, RES_NONE);
    add_row(0, '0, KIND_ENQ, 0, 0, 1, op_result_t'({6'd0, 1'b0, 8'h00, 1'b1}));
    add_row(0, '0, KIND_ENQ, 7, 63, 1, op_result_t'({6'd0, 1'b0, 8'h00, 1'b1}));
    add_row(0, '0, KIND_DEQ, 0, 0, 1, op_result_t'({6'd0, 1'b1, 8'h00, 1'b0}));
    add_row(0, '0, KIND_DEQ, 0, 0, 1, RES_NONE);
    add_row(0, '0, KIND_DEQ, 7, 0, 1, op_result_t'({6'd63, 1'b1, 8'h00, 1'b0}));
    // All-ones codes: a list of three, refilled while draining
    add_row(1, '1, KIND_ENQ, 1, 10, 1, op_result_t'({6'd0, 1'b0, 8'hFF, 1'b1}));
    add_row(0, '0, KIND_ENQ, 1, 20, 0, RES_NONE);
    add_row(0, '0, KIND_ENQ, 1, 30, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 1, 0, 0, RES_NONE);
    add_row(0, '0, KIND_ENQ, 1, 40, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 1, 0, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 1, 0, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 1, 0, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 1, 0, 1, RES_NONE);
    // Tail buffer queued twice links to itself, a later enqueue breaks the loop
    add_row(0, '0, KIND_ENQ, 2, 7, 0, RES_NONE);
    add_row(0, '0, KIND_ENQ, 2, 7, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 2, 0, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 2, 0, 0, RES_NONE);
    add_row(0, '0, KIND_ENQ, 2, 8, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 2, 0, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 2, 0, 0, RES_NONE);
    // Distinct codes per queue; one buffer placed in two queues
    add_row(1, 64'h8040201008040201, KIND_ENQ, 4, 9, 0, RES_NONE);
    add_row(0, '0, KIND_ENQ, 5, 9, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 4, 0, 0, RES_NONE);
    add_row(0, '0, KIND_DEQ, 5, 0, 0, RES_NONE);

    // Hold reset for the first cycles, release it at a falling edge
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.set_codes) write_event_codes(row.codes);
      issue_item(row.kind, row.queue, row.buffer, row.typed, row.result);
      idle_for(pick_gap());
    end
    // Directed rows leave every queue empty; forget stale buffer marks
    drain_results();
    for (int i = 0; i < NUM_B; i++) buf_in_use[i] = 1'b0;

    // Random phases, one back-to-back stretch among them
    write_event_codes({$urandom, $urandom});
    run_random_phase(125, 1'b0);
    write_event_codes('0);
    run_random_phase(125, 1'b1);
    write_event_codes('1);
    run_random_phase(125, 1'b0);
    write_event_codes({$urandom, $urandom});
    run_random_phase(125, 1'b0);

    // Wait out the last results and a few spare cycles
    drain_results();
    repeat (10) @(negedge clk);
    if (awaited_results.size() != 0) err_cnt++;

    $display("Ran %0d items: %0d enqueues, %0d buffers returned, %0d empty dequeues",
             item_cnt, enq_cnt, returned_cnt, empty_cnt);
    $display("Event code register written %0d times; %0d failures", codes_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
